// File: src/plcm_pkg.sv
`default_nettype none
package plcm_pkg;
    localparam int MaxPointsDefault = 16;
    localparam int SamplesDefault = 1024;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] level;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic signed [15:0] pos;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
    } stop_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_INSERT,
        S_L_RD0, S_L_DIV1, S_L_W1, S_L_SRCH_RD, S_L_SRCH, S_L_UP_RD, S_L_UP,
        S_L_DIV2, S_L_W2, S_L_MIX, S_DONE
    } state_t;
endpackage
`default_nettype wire

// File: src/plcm_ram.sv
`default_nettype none
module plcm_ram #(
    parameter int Width = 40,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: src/plcm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Unsigned operands.
module plcm_div #(
    parameter int Width = 40
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [Width-1:0] num,
    input  wire logic [Width-1:0] den,
    output logic                  done,
    output logic      [Width-1:0] quot
);
    localparam int CntW = $clog2(Width + 1);

    logic [Width-1:0] q_reg, q_next;
    logic [Width:0]   rem_reg, rem_next;
    logic [Width-1:0] d_reg, d_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [Width:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[Width-1:0], q_reg[Width-1]};
        if (go)
        begin
            q_next    = num;
            rem_next  = '0;
            d_next    = den;
            cnt_next  = CntW'(Width);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[Width-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[Width-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

// File: src/piecewise_linear_colormap.sv
`default_nettype none
// Color map with up to MAX_POINTS stops held in a small RAM, sorted by descending position.
// One command at a time: busy is high from the cycle after start until the result strobe.
// An add scans the stops down to its slot and then moves the stops below the slot down one
// place. A lookup uses up to two passes of the shared bit-serial divider, searches the stops,
// and then sets up and mixes the three colors. A clear goes straight to the result.
// The result is on result for one cycle with done high; the receiver cannot stall it,
// so take it then.
module piecewise_linear_colormap
    import plcm_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault,
    parameter int SAMPLES    = SamplesDefault
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire plcm_pkg::cmd_t cmd,
    output logic                busy,
    output logic                done,
    output plcm_pkg::res_t      result
);
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SW   = $clog2(SAMPLES) + 1;
    localparam int PW   = 17 + SW + 1;
    localparam int DW   = PW + 16;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    res_t   res_reg, res_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] ins_reg, ins_next;
    logic signed [15:0] lo_reg, lo_next, hi_reg, hi_next;
    stop_t up_reg, up_next, dn_reg, dn_next;
    logic signed [PW-1:0] p_reg, p_next;
    logic [16:0] r_reg, r_next;
    logic [1:0]  ch_reg, ch_next;
    logic        done_reg, done_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    stop_t         wdata, rdata;
    logic          dgo, ddone;
    logic [DW-1:0] dnum, dden, dquot;

    plcm_ram #(.Width($bits(stop_t)), .Depth(MAX_POINTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    plcm_div #(.Width(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
        .done(ddone), .quot(dquot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
        ins_reg <= ins_next;
        up_reg  <= up_next;
        dn_reg  <= dn_next;
        p_reg   <= p_next;
        r_reg   <= r_next;
        ch_reg  <= ch_next;
    end

    logic signed [16:0] vcl, span;
    logic signed [PW-1:0] dn_scaled, num2, den2;
    logic [8+17:0] mix;
    logic [7:0] cu, cd;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ins_next   = ins_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        up_next    = up_reg;
        dn_next    = dn_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        ch_next    = ch_reg;
        done_next  = 1'b0;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = rdata;
        raddr      = idx_reg[AW-1:0];
        dgo        = 1'b0;
        dnum       = '0;
        dden       = '0;
        span       = 17'(hi_reg) - 17'(lo_reg);
        vcl        = 17'(cmd_reg.level);
        if (cmd_reg.level < lo_reg)
        begin
            vcl = 17'(lo_reg);
        end
        else if (cmd_reg.level > hi_reg)
        begin
            vcl = 17'(hi_reg);
        end
        dn_scaled  = PW'(rdata.pos) * PW'(SAMPLES);
        num2       = p_reg - PW'(dn_reg.pos) * PW'(SAMPLES);
        den2       = (PW'(up_reg.pos) - PW'(dn_reg.pos)) * PW'(SAMPLES);
        cu = up_reg.r;
        cd = dn_reg.r;
        case (ch_reg)
            2'd1:
            begin
                cu = up_reg.g;
                cd = dn_reg.g;
            end
            2'd2:
            begin
                cu = up_reg.b;
                cd = dn_reg.b;
            end
            default:
            begin
            end
        endcase
        mix = 26'(cu) * 26'(r_reg) + 26'(cd) * 26'(17'h10000 - r_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    idx_next = '0;
                    case (cmd.req_type)
                        REQ_LOOKUP: state_next = S_L_RD0;
                        REQ_ADD:
                        begin
                            ins_next   = count_reg;
                            state_next = S_SCAN_RD;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            // Add: find insertion point, checking duplicates.
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (count_reg >= CW'(MAX_POINTS))
                    begin
                        res_next.status = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = (count_reg == ins_reg) ? S_INSERT : S_SHIFT_RD;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmd_reg.level == rdata.pos)
                begin
                    res_next.status = ST_DUP;
                    state_next = S_DONE;
                end
                else if (cmd_reg.level > rdata.pos)
                begin
                    ins_next = idx_reg;
                    idx_next = count_reg;
                    if (count_reg >= CW'(MAX_POINTS))
                    begin
                        res_next.status = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            // idx_reg is the destination; read the entry just above it.
            S_SHIFT_RD:
            begin
                raddr      = AW'(idx_reg - 1'b1);
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                we       = 1'b1;
                wdata    = rdata;
                idx_next = idx_reg - 1'b1;
                state_next = ((idx_reg - 1'b1) == ins_reg) ? S_INSERT : S_SHIFT_RD;
            end
            S_INSERT:
            begin
                we    = 1'b1;
                waddr = ins_reg[AW-1:0];
                wdata = '{pos: cmd_reg.level, r: cmd_reg.red_in, g: cmd_reg.green_in,
                          b: cmd_reg.blue_in};
                count_next = count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    lo_next = cmd_reg.level;
                    hi_next = cmd_reg.level;
                end
                else if (cmd_reg.level < lo_reg)
                begin
                    lo_next = cmd_reg.level;
                end
                else if (cmd_reg.level > hi_reg)
                begin
                    hi_next = cmd_reg.level;
                end
                state_next = S_DONE;
            end
            // Lookup.
            S_L_RD0:
            begin
                raddr = '0;
                if (count_reg == '0)
                begin
                    res_next = '{red_out: 8'hFF, green_out: 8'hFF, blue_out: 8'hFF,
                                 status: ST_EMPTY};
                    state_next = S_DONE;
                end
                else if (count_reg == CW'(1) || span <= 0)
                begin
                    state_next = S_L_W1;
                    up_next.pos = '0;
                    r_next = '0;
                    dgo = 1'b0;
                    state_next = S_L_DIV1;
                    idx_next = '0;
                end
                else
                begin
                    dgo  = 1'b1;
                    dnum = DW'(unsigned'(vcl - 17'(lo_reg))) * DW'(SAMPLES);
                    dden = DW'(unsigned'(span));
                    state_next = S_L_DIV1;
                    idx_next = CW'(1);
                end
            end
            S_L_DIV1:
            begin
                // idx_reg zero marks the single-color path.
                if (idx_reg == '0)
                begin
                    res_next.red_out   = rdata.r;
                    res_next.green_out = rdata.g;
                    res_next.blue_out  = rdata.b;
                    state_next = S_DONE;
                end
                else if (ddone)
                begin
                    p_next = PW'(lo_reg) * PW'(SAMPLES) + PW'(dquot[SW-1:0]) * PW'(span);
                    state_next = S_L_SRCH_RD;
                end
            end
            S_L_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    idx_next   = count_reg - 1'b1;
                    ins_next   = '0;
                    state_next = S_L_UP_RD;
                end
                else
                begin
                    state_next = S_L_SRCH;
                end
            end
            S_L_SRCH:
            begin
                if (p_reg > dn_scaled)
                begin
                    ins_next   = idx_reg - 1'b1;
                    state_next = S_L_UP_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_L_SRCH_RD;
                end
            end
            // ins_reg holds the upper index, idx_reg the lower; read upper first.
            S_L_UP_RD:
            begin
                raddr      = ins_reg[AW-1:0];
                state_next = S_L_UP;
            end
            S_L_UP:
            begin
                raddr      = idx_reg[AW-1:0];
                up_next    = rdata;
                state_next = S_L_W1;
            end
            S_L_W1:
            begin
                dn_next    = rdata;
                state_next = S_L_W2;
            end
            S_L_W2:
            begin
                if (den2 <= 0 || num2 <= 0)
                begin
                    r_next     = '0;
                    ch_next    = '0;
                    state_next = S_L_MIX;
                end
                else
                begin
                    dgo  = 1'b1;
                    dnum = DW'(unsigned'(num2)) << 16;
                    dden = DW'(unsigned'(den2));
                    state_next = S_L_DIV2;
                end
            end
            S_L_DIV2:
            begin
                if (ddone)
                begin
                    r_next     = (dquot > DW'(17'h10000)) ? 17'h10000 : dquot[16:0];
                    ch_next    = '0;
                    state_next = S_L_MIX;
                end
            end
            S_L_MIX:
            begin
                case (ch_reg)
                    2'd0: res_next.red_out = mix[23:16];
                    2'd1: res_next.green_out = mix[23:16];
                    default: res_next.blue_out = mix[23:16];
                endcase
                ch_next = ch_reg + 1'b1;
                if (ch_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS)) else $error("stop count overflow");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> lo_reg <= hi_reg) else $error("range inverted");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE) else $error("strobe outside idle");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == '0 || count_reg == $past(count_reg) + 1'b1)
        else $error("count jumped");
endmodule
`default_nettype wire

// File: tb/piecewise_linear_colormap_tb.sv
`default_nettype none
module piecewise_linear_colormap_tb;
    import plcm_pkg::*;

    localparam int NumStops = MaxPointsDefault;
    localparam int NumSamples = SamplesDefault;
    localparam int WatchdogLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy;
    logic done;
    res_t result;

    piecewise_linear_colormap DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always #5 clk = ~clk;

    // Shadow copy of the color table.
    logic signed [15:0] stop_pos [NumStops];
    logic [7:0] stop_red [NumStops];
    logic [7:0] stop_green [NumStops];
    logic [7:0] stop_blue [NumStops];
    int stop_total = 0;
    int lowest_level = 0;
    int highest_level = 0;

    cmd_t pending_cmds [$];
    res_t expected_colors [$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    bit stimulus_done = 1'b0;

    function automatic res_t lookup_color(input int lv);
        res_t res;
        int v;
        longint span, idx, pt, num, den, weight, mix;
        int up, dn;
        res = '0;
        if (stop_total == 0)
        begin
            res.red_out = 8'd255;
            res.green_out = 8'd255;
            res.blue_out = 8'd255;
            res.status = ST_EMPTY;
            return res;
        end
        v = lv;
        if (v < lowest_level) v = lowest_level;
        else if (v > highest_level) v = highest_level;
        span = longint'(highest_level) - lowest_level;
        if (stop_total == 1 || span <= 0)
        begin
            res.red_out = stop_red[0];
            res.green_out = stop_green[0];
            res.blue_out = stop_blue[0];
            return res;
        end
        idx = ((longint'(v) - lowest_level) * NumSamples) / span;
        pt = longint'(lowest_level) * NumSamples + idx * span;
        up = 0;
        dn = stop_total - 1;
        for (int i = 1; i < stop_total; i++)
        begin
            if (pt > longint'(stop_pos[i]) * NumSamples)
            begin
                up = i - 1;
                dn = i;
                break;
            end
        end
        num = pt - longint'(stop_pos[dn]) * NumSamples;
        den = (longint'(stop_pos[up]) - longint'(stop_pos[dn])) * NumSamples;
        if (den <= 0 || num <= 0) weight = 0;
        else weight = (num * 65536) / den;
        if (weight > 65536) weight = 65536;
        mix = longint'(stop_red[up]) * weight + longint'(stop_red[dn]) * (65536 - weight);
        res.red_out = 8'(mix >>> 16);
        mix = longint'(stop_green[up]) * weight + longint'(stop_green[dn]) * (65536 - weight);
        res.green_out = 8'(mix >>> 16);
        mix = longint'(stop_blue[up]) * weight + longint'(stop_blue[dn]) * (65536 - weight);
        res.blue_out = 8'(mix >>> 16);
        return res;
    endfunction

    function automatic res_t insert_stop(input cmd_t c);
        res_t res;
        int slot;
        int lv;
        res = '0;
        lv = c.level;
        slot = stop_total;
        for (int i = 0; i < stop_total; i++)
        begin
            if (lv == stop_pos[i])
            begin
                res.status = ST_DUP;
                return res;
            end
            if (lv > stop_pos[i])
            begin
                slot = i;
                break;
            end
        end
        if (stop_total >= NumStops)
        begin
            res.status = ST_FULL;
            return res;
        end
        for (int i = stop_total; i > slot; i--)
        begin
            stop_pos[i] = stop_pos[i - 1];
            stop_red[i] = stop_red[i - 1];
            stop_green[i] = stop_green[i - 1];
            stop_blue[i] = stop_blue[i - 1];
        end
        stop_pos[slot] = c.level;
        stop_red[slot] = c.red_in;
        stop_green[slot] = c.green_in;
        stop_blue[slot] = c.blue_in;
        stop_total++;
        if (stop_total == 1)
        begin
            lowest_level = lv;
            highest_level = lv;
        end
        else if (lv < lowest_level)
        begin
            lowest_level = lv;
        end
        else if (lv > highest_level)
        begin
            highest_level = lv;
        end
        return res;
    endfunction

    function automatic res_t predict_color(input cmd_t c);
        res_t res;
        res = '0;
        case (req_t'(c.req_type))
            REQ_LOOKUP: res = lookup_color(c.level);
            REQ_ADD: res = insert_stop(c);
            REQ_CLEAR: stop_total = 0;
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic cmd_t make_cmd(input req_t kind, input int lv);
        cmd_t c;
        c.req_type = kind;
        c.level = 16'(lv);
        c.red_in = 8'($urandom_range(0, 255));
        c.green_in = 8'($urandom_range(0, 255));
        c.blue_in = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void enqueue_cmd(input cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // Driver: a transfer happens at an edge with start high and busy low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!(start && !busy))
            begin
                if (!start && pending_cmds.size() > 0
                        && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    start <= 1'b1;
                    cmd <= pending_cmds.pop_front();
                end
            end
            else
            begin
                expected_colors.insert(expected_colors.size(), predict_color(cmd));
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    cmd <= pending_cmds.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_colors.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %h", result);
            end
            else
            begin
                res_t want;
                want = expected_colors.pop_front();
                if (result.red_out !== want.red_out || result.green_out !== want.green_out
                        || result.blue_out !== want.blue_out
                        || result.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected rgb %0d %0d %0d status %0d, got %0d %0d %0d %0d",
                            want.red_out, want.green_out, want.blue_out, want.status,
                            result.red_out, result.green_out, result.blue_out, result.status);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_add(input int lv);
        enqueue_cmd(make_cmd(REQ_ADD, lv));
    endtask

    task automatic queue_lookup(input int lv);
        enqueue_cmd(make_cmd(REQ_LOOKUP, lv));
    endtask

    task automatic wait_drained;
        while (pending_cmds.size() > 0 || start) @(posedge clk);
    endtask

    function automatic int random_level();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32767 : -32768;
            1: return $urandom_range(0, 65535) - 32768;
            default: return $urandom_range(0, 1023) - 512;
        endcase
    endfunction

    initial
    begin
        cmd_t junk;
        int phase_pct [4];
        phase_pct = '{0, 80, 0, 38};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty lookup, single stop, zero range, extremes, full, duplicate.
        queue_lookup(0);
        queue_add(-32768);
        queue_lookup(32767);
        enqueue_cmd(make_cmd(REQ_CLEAR, 0));
        queue_lookup(5);
        queue_add(100);
        queue_add(100);
        queue_lookup(-32768);
        queue_add(32767);
        pending_cmds[$].red_in = 8'hFF;
        pending_cmds[$].green_in = 8'h00;
        pending_cmds[$].blue_in = 8'hAA;
        queue_add(-32768);
        pending_cmds[$].red_in = 8'h00;
        pending_cmds[$].green_in = 8'hFF;
        pending_cmds[$].blue_in = 8'h55;
        queue_lookup(0);
        queue_lookup(32767);
        queue_lookup(-32768);
        for (int i = 0; i < 13; i++) queue_add(i * 37 - 200);
        queue_add(7);
        queue_add(100);
        queue_lookup(-50);
        junk = make_cmd(REQ_NONE, 12345);
        junk.level = 16'hFFFF;
        enqueue_cmd(junk);
        enqueue_cmd(make_cmd(REQ_CLEAR, 0));
        wait_drained();

        // Random: mostly build a table then look it up, with some noise.
        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = phase_pct[ph];
            for (int n = 0; n < 250; )
            begin
                int adds;
                adds = $urandom_range(0, 18);
                for (int k = 0; k < adds && n < 250; k++, n++) queue_add(random_level());
                for (int k = 0; k < 12 && n < 250; k++, n++)
                begin
                    int pick;
                    pick = $urandom_range(0, 19);
                    if (pick == 0) enqueue_cmd(make_cmd(REQ_NONE, random_level()));
                    else if (pick == 1) queue_add(random_level());
                    else queue_lookup(random_level());
                end
                enqueue_cmd(make_cmd(REQ_CLEAR, random_level()));
                n++;
            end
            wait_drained();
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        wait (stimulus_done);
        while (expected_colors.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_colors.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
src/plcm_pkg.sv
src/plcm_ram.sv
src/plcm_div.sv
src/piecewise_linear_colormap.sv
tb/piecewise_linear_colormap_tb.sv
